>>> hdl/ptgf_pkg.sv
package ptgf_pkg;

    // Window geometry.
    localparam int WINDOW_LEN = 7;
    localparam int MID        = (WINDOW_LEN - 1) / 2;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

    // Signed Q5.11 samples.
    localparam int VAL_W    = 16;
    localparam int FRAC_W   = 11;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int WIDE_W   = VAL_W + 3;
    localparam int E_W      = FRAC_W + 1;
    localparam int OCT_HALF = 1 << (FRAC_W - 1);

    // Interpolation step and its divider.
    localparam int MAG_W     = $clog2(MID * OCT_HALF + 1);
    localparam int PROD_W    = MAG_W + 1;
    localparam int DIV_STEPS = (MAG_W + 3) / 2;
    localparam int DIVQ_W    = 2 * DIV_STEPS;
    localparam int DEN_W     = IDX_W + 1;
    localparam int REM_W     = IDX_W + 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int SUM_W     = VAL_W + 2;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OCT,
        S_PREP,
        S_DIV,
        S_SUM,
        S_DONE
    } state_t;

endpackage

>>> hdl/ptgf_in_if.sv
interface ptgf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   pitch_valid;
    logic signed [ptgf_pkg::VAL_W-1:0]      pitch_log2;

    modport source (output valid, output pitch_valid, output pitch_log2, input ready);
    modport sink   (input valid, input pitch_valid, input pitch_log2, output ready);
endinterface

>>> hdl/ptgf_out_if.sv
interface ptgf_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   smoothed_valid;
    logic signed [ptgf_pkg::VAL_W-1:0]      smoothed_log2;

    modport source (output valid, output smoothed_valid, output smoothed_log2, input ready);
    modport sink   (input valid, input smoothed_valid, input smoothed_log2, output ready);
endinterface

>>> hdl/pitch_track_gap_filler.sv
// Every accepted word enters a seven-entry sliding window; once it is full each word yields
// one result word for the window centre. Reset empties the window and the output register.
// A result is loaded straight after the scan when the centre is valid or lacks a valid
// neighbour on a side, else after the two-bit-per-cycle divider has worked out the gap.
// Throughput: one word per cycle while filling, else one word at a time; a result that
// still waits in the output register holds the next one, and with it the input, back.
module pitch_track_gap_filler (
    input  logic            clk,
    input  logic            rst_n,
    ptgf_in_if.sink         pitch,
    ptgf_out_if.source      smoothed
);

    ptgf_pkg::state_t state_reg, state_next;

    logic signed [ptgf_pkg::VAL_W-1:0]  win_val_reg [ptgf_pkg::WINDOW_LEN];
    logic [ptgf_pkg::WINDOW_LEN-1:0]    win_vld_reg;
    logic [ptgf_pkg::CNT_W-1:0]         fill_reg;

    logic signed [ptgf_pkg::VAL_W-1:0]  a_reg, b_reg;
    logic [ptgf_pkg::IDX_W-1:0]         lw_reg, span_reg;
    logic signed [ptgf_pkg::E_W-1:0]    e_reg;
    logic                               neg_reg;
    logic [ptgf_pkg::DIVQ_W-1:0]        num_reg, quo_reg;
    logic [ptgf_pkg::DEN_W-1:0]         den_reg;
    logic [ptgf_pkg::REM_W-1:0]         rem_reg;
    logic [ptgf_pkg::STEP_W-1:0]        cnt_reg;
    logic                               res_vld_reg;
    logic signed [ptgf_pkg::VAL_W-1:0]  res_reg;

    logic                               out_valid_reg;
    logic                               out_sv_reg;
    logic signed [ptgf_pkg::VAL_W-1:0]  out_log2_reg;

    logic accept, last_fill, div_last, load_out, take_out;

    // Neighbour search.
    logic                               found_l, found_r;
    logic [ptgf_pkg::IDX_W-1:0]         idx_l, idx_r;
    logic signed [ptgf_pkg::VAL_W-1:0]  val_l, val_r;

    // Octave fold.
    logic signed [ptgf_pkg::DIFF_W-1:0] d_w;
    logic [ptgf_pkg::DIFF_W-1:0]        d_mag;
    logic [ptgf_pkg::DIFF_W:0]          oct_sum;
    logic signed [ptgf_pkg::WIDE_W-1:0] oct_shift, e_full;

    // Divider set-up and step.
    logic signed [ptgf_pkg::PROD_W-1:0] prod_w;
    logic [ptgf_pkg::MAG_W-1:0]         prod_mag;
    logic [ptgf_pkg::REM_W-1:0]         rem_w;
    logic [ptgf_pkg::DIVQ_W-1:0]        num_w, quo_w;

    // Final sum.
    logic signed [ptgf_pkg::SUM_W-1:0]  step_w, sum_w;
    logic signed [ptgf_pkg::VAL_W-1:0]  sat_w;

    assign accept    = pitch.valid && pitch.ready;
    assign last_fill = (fill_reg >= ptgf_pkg::CNT_W'(ptgf_pkg::WINDOW_LEN - 1));
    assign div_last  = (cnt_reg == ptgf_pkg::STEP_W'(ptgf_pkg::DIV_STEPS - 1));
    assign take_out  = smoothed.valid && smoothed.ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptgf_pkg::S_IDLE:
            begin
                if (accept && last_fill)
                begin
                    state_next = ptgf_pkg::S_SCAN;
                end
            end
            ptgf_pkg::S_SCAN:
            begin
                if (win_vld_reg[ptgf_pkg::MID] || !found_l || !found_r)
                begin
                    state_next = ptgf_pkg::S_DONE;
                end
                else
                begin
                    state_next = ptgf_pkg::S_OCT;
                end
            end
            ptgf_pkg::S_OCT:  state_next = ptgf_pkg::S_PREP;
            ptgf_pkg::S_PREP: state_next = ptgf_pkg::S_DIV;
            ptgf_pkg::S_DIV:
            begin
                if (div_last)
                begin
                    state_next = ptgf_pkg::S_SUM;
                end
            end
            ptgf_pkg::S_SUM:  state_next = ptgf_pkg::S_DONE;
            ptgf_pkg::S_DONE:
            begin
                if (!out_valid_reg || smoothed.ready)
                begin
                    state_next = ptgf_pkg::S_IDLE;
                end
            end
            default: state_next = ptgf_pkg::S_IDLE;
        endcase
    end

    // Output and strobe logic.
    always_comb
    begin
        pitch.ready = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ptgf_pkg::S_IDLE: pitch.ready = 1'b1;
            ptgf_pkg::S_DONE: load_out    = !out_valid_reg || smoothed.ready;
            default:
            begin
                pitch.ready = 1'b0;
                load_out    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptgf_pkg::S_IDLE;
            win_vld_reg   <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                win_vld_reg <= {pitch.pitch_valid, win_vld_reg[ptgf_pkg::WINDOW_LEN-1:1]};
                if (fill_reg < ptgf_pkg::CNT_W'(ptgf_pkg::WINDOW_LEN))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (take_out)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Index 0 holds the oldest word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < ptgf_pkg::WINDOW_LEN - 1; k++)
            begin
                win_val_reg[k] <= win_val_reg[k+1];
            end
            win_val_reg[ptgf_pkg::WINDOW_LEN-1] <= pitch.pitch_log2;
        end
    end

    // Nearest valid entry on each side of the centre; later hits overwrite earlier ones.
    always_comb
    begin
        found_l = 1'b0;
        found_r = 1'b0;
        idx_l   = '0;
        idx_r   = '0;
        val_l   = '0;
        val_r   = '0;
        for (int k = 0; k < ptgf_pkg::MID; k++)
        begin
            if (win_vld_reg[k])
            begin
                found_l = 1'b1;
                idx_l   = ptgf_pkg::IDX_W'(k);
                val_l   = win_val_reg[k];
            end
        end
        for (int k = ptgf_pkg::WINDOW_LEN - 1; k > ptgf_pkg::MID; k--)
        begin
            if (win_vld_reg[k])
            begin
                found_r = 1'b1;
                idx_r   = ptgf_pkg::IDX_W'(k);
                val_r   = win_val_reg[k];
            end
        end
    end

    // Fold the right neighbour by the nearest whole octave, ties away from zero.
    always_comb
    begin
        d_w       = ptgf_pkg::DIFF_W'(b_reg) - ptgf_pkg::DIFF_W'(a_reg);
        d_mag     = d_w[ptgf_pkg::DIFF_W-1] ? ptgf_pkg::DIFF_W'(-d_w) : ptgf_pkg::DIFF_W'(d_w);
        oct_sum   = (ptgf_pkg::DIFF_W+1)'(d_mag) + (ptgf_pkg::DIFF_W+1)'(ptgf_pkg::OCT_HALF);
        oct_shift = $signed({1'b0, oct_sum[ptgf_pkg::DIFF_W:ptgf_pkg::FRAC_W],
                             {ptgf_pkg::FRAC_W{1'b0}}});
        if (d_w[ptgf_pkg::DIFF_W-1])
        begin
            e_full = ptgf_pkg::WIDE_W'(d_w) + oct_shift;
        end
        else
        begin
            e_full = ptgf_pkg::WIDE_W'(d_w) - oct_shift;
        end
    end

    always_comb
    begin
        prod_w   = $signed({1'b0, lw_reg}) * ptgf_pkg::PROD_W'(e_reg);
        prod_mag = prod_w[ptgf_pkg::PROD_W-1] ? ptgf_pkg::MAG_W'(-prod_w)
                                              : ptgf_pkg::MAG_W'(prod_w);
    end

    // Two restoring division steps per cycle.
    always_comb
    begin
        rem_w = rem_reg;
        num_w = num_reg;
        quo_w = quo_reg;
        for (int s = 0; s < 2; s++)
        begin
            rem_w = {rem_w[ptgf_pkg::REM_W-2:0], num_w[ptgf_pkg::DIVQ_W-1]};
            num_w = {num_w[ptgf_pkg::DIVQ_W-2:0], 1'b0};
            if (rem_w >= ptgf_pkg::REM_W'(den_reg))
            begin
                rem_w = rem_w - ptgf_pkg::REM_W'(den_reg);
                quo_w = {quo_w[ptgf_pkg::DIVQ_W-2:0], 1'b1};
            end
            else
            begin
                quo_w = {quo_w[ptgf_pkg::DIVQ_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        step_w = neg_reg ? -ptgf_pkg::SUM_W'(quo_reg) : ptgf_pkg::SUM_W'(quo_reg);
        sum_w  = ptgf_pkg::SUM_W'(a_reg) + step_w;
        if (sum_w > ptgf_pkg::SUM_W'(ptgf_pkg::VAL_MAX))
        begin
            sat_w = ptgf_pkg::VAL_MAX;
        end
        else if (sum_w < ptgf_pkg::SUM_W'(ptgf_pkg::VAL_MIN))
        begin
            sat_w = ptgf_pkg::VAL_MIN;
        end
        else
        begin
            sat_w = sum_w[ptgf_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ptgf_pkg::S_SCAN:
            begin
                a_reg    <= val_l;
                b_reg    <= val_r;
                lw_reg   <= ptgf_pkg::IDX_W'(ptgf_pkg::MID) - idx_l;
                span_reg <= idx_r - idx_l;
                if (win_vld_reg[ptgf_pkg::MID])
                begin
                    res_vld_reg <= 1'b1;
                    res_reg     <= win_val_reg[ptgf_pkg::MID];
                end
                else
                begin
                    res_vld_reg <= found_l && found_r;
                    res_reg     <= '0;
                end
            end
            ptgf_pkg::S_OCT:
            begin
                e_reg <= e_full[ptgf_pkg::E_W-1:0];
            end
            ptgf_pkg::S_PREP:
            begin
                neg_reg <= prod_w[ptgf_pkg::PROD_W-1];
                num_reg <= ptgf_pkg::DIVQ_W'({prod_mag, 1'b0}) + ptgf_pkg::DIVQ_W'(span_reg);
                den_reg <= {span_reg, 1'b0};
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ptgf_pkg::S_DIV:
            begin
                rem_reg <= rem_w;
                num_reg <= num_w;
                quo_reg <= quo_w;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ptgf_pkg::S_SUM:
            begin
                res_reg <= sat_w;
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_sv_reg   <= res_vld_reg;
            out_log2_reg <= res_reg;
        end
    end

    assign smoothed.valid          = out_valid_reg;
    assign smoothed.smoothed_valid = out_sv_reg;
    assign smoothed.smoothed_log2  = out_log2_reg;

endmodule

>>> hdl/ptgf_checker.sv
module ptgf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             out_sv,
    input logic signed [ptgf_pkg::VAL_W-1:0] out_log2
);

    // A result word that is waiting stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn before it was taken");

    // A waiting result word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sv) && $stable(out_log2))
        else $error("result payload changed while stalled");

    // An empty result carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_sv |-> out_log2 == '0)
        else $error("invalid result with a non-zero value");

    // A fresh result word is only loaded while the input side is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the input side was open");

endmodule

bind pitch_track_gap_filler ptgf_checker u_ptgf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pitch.valid),
    .in_ready  (pitch.ready),
    .out_valid (smoothed.valid),
    .out_ready (smoothed.ready),
    .out_sv    (smoothed.smoothed_valid),
    .out_log2  (smoothed.smoothed_log2)
);

>>> bench/pitch_track_gap_filler_test.sv
`timescale 1ns / 1ps

module pitch_track_gap_filler_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 650;
    localparam int MAX_PRINTED  = 100;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                             sv;
        logic signed [ptgf_pkg::VAL_W-1:0] lv;
    } centre_t;

    typedef struct packed {
        logic                             pv;
        logic signed [ptgf_pkg::VAL_W-1:0] pl;
        bit                               fixed_exp;
        logic                             ev;
        logic signed [ptgf_pkg::VAL_W-1:0] el;
    } row_t;

    // Rows with fixed_exp set carry a result that can be read off directly: pass-through
    // centres, windows with no neighbour on one side, and fills that saturate.
    localparam row_t DIRECTED_ROWS [22] = '{
        '{1'b1, 16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
        '{1'b1, 16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{1'b1, 16'sd100,  1'b0, 1'b0, 16'sh0000},
        '{1'b0, 16'sh1234, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{1'b1, 16'sh7FFF, 1'b1, 1'b1, 16'sd100},
        '{1'b0, 16'shFFFF, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b1, 1'b1, 16'sh7FFF},
        '{1'b0, 16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{1'b1, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{1'b1, 16'sh7BFF, 1'b1, 1'b0, 16'sh0000},
        '{1'b1, 16'sh8000, 1'b1, 1'b1, 16'sh7FFF},
        '{1'b0, 16'sh0000, 1'b1, 1'b1, 16'sh7FFF},
        '{1'b1, 16'sh8400, 1'b1, 1'b1, 16'sh7BFF},
        '{1'b0, 16'shFFFF, 1'b1, 1'b1, 16'sh8000},
        '{1'b0, 16'sh0000, 1'b1, 1'b1, 16'sh8000}
    };

    logic clk;
    logic rst_n;

    ptgf_in_if  pitch_if ();
    ptgf_out_if smoothed_if ();

    pitch_track_gap_filler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pitch    (pitch_if),
        .smoothed (smoothed_if)
    );

    int src_idle_pct;
    int snk_idle_pct;
    int err_count;
    int cycles;

    // Shadow of the block's sliding window.
    logic signed [ptgf_pkg::VAL_W-1:0] win_val [ptgf_pkg::WINDOW_LEN];
    logic                              win_ok  [ptgf_pkg::WINDOW_LEN];
    int                                win_fill;

    centre_t centre_q [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic note_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        err_count++;
    endtask

    // Divides by a positive denominator, rounding to nearest with ties away from zero.
    function automatic int round_div(input int num, input int den);
        int mag;
        int q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic void advance_window(input logic pv,
                                           input logic signed [ptgf_pkg::VAL_W-1:0] pl,
                                           output bit produced, output centre_t res);
        int i;
        int j;
        int a;
        int d;
        int e;
        int fill;
        res = '0;
        produced = 1'b0;
        for (int k = 0; k < ptgf_pkg::WINDOW_LEN - 1; k++)
        begin
            win_val[k] = win_val[k + 1];
            win_ok[k]  = win_ok[k + 1];
        end
        win_val[ptgf_pkg::WINDOW_LEN - 1] = pl;
        win_ok[ptgf_pkg::WINDOW_LEN - 1]  = pv;
        if (win_fill < ptgf_pkg::WINDOW_LEN)
            win_fill++;
        if (win_fill < ptgf_pkg::WINDOW_LEN)
            return;
        produced = 1'b1;
        if (win_ok[ptgf_pkg::MID])
        begin
            res.sv = 1'b1;
            res.lv = win_val[ptgf_pkg::MID];
            return;
        end
        i = ptgf_pkg::MID;
        while (i >= 0 && !win_ok[i])
            i--;
        j = ptgf_pkg::MID;
        while (j < ptgf_pkg::WINDOW_LEN && !win_ok[j])
            j++;
        if (i < 0 || j >= ptgf_pkg::WINDOW_LEN)
            return;
        a = int'(win_val[i]);
        d = int'(win_val[j]) - a;
        // Pull the right neighbour to within half an octave of the left one.
        e = d - round_div(d, 2048) * 2048;
        fill = a + round_div((ptgf_pkg::MID - i) * e, j - i);
        if (fill > 32767)
            fill = 32767;
        if (fill < -32768)
            fill = -32768;
        res.sv = 1'b1;
        res.lv = ptgf_pkg::VAL_W'(fill);
    endfunction

    task automatic send_word(input logic pv, input logic signed [ptgf_pkg::VAL_W-1:0] pl,
                             input bit use_fixed, input centre_t fixed_res);
        bit      produced;
        centre_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            pitch_if.valid <= 1'b0;
            @(posedge clk);
        end
        pitch_if.valid       <= 1'b1;
        pitch_if.pitch_valid <= pv;
        pitch_if.pitch_log2  <= pl;
        @(posedge clk);
        while (!pitch_if.ready)
            @(posedge clk);
        advance_window(pv, pl, produced, res);
        if (produced)
            centre_q.push_back(use_fixed ? fixed_res : res);
    endtask

    // Result side: random back-pressure and the comparison against the oldest expectation.
    initial
    begin
        centre_t want;
        smoothed_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && smoothed_if.valid && smoothed_if.ready)
            begin
                if (centre_q.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected word valid=%0b log2=%0d",
                                            smoothed_if.smoothed_valid,
                                            smoothed_if.smoothed_log2));
                end
                else
                begin
                    want = centre_q.pop_front();
                    if (smoothed_if.smoothed_valid !== want.sv)
                        note_mismatch($sformatf("smoothed_valid got %0b want %0b",
                                                smoothed_if.smoothed_valid, want.sv));
                    if (smoothed_if.smoothed_log2 !== want.lv)
                        note_mismatch($sformatf("smoothed_log2 got %0d want %0d",
                                                smoothed_if.smoothed_log2, want.lv));
                end
            end
            smoothed_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int                                track;
        int                                gap_left;
        logic                              pv;
        logic signed [ptgf_pkg::VAL_W-1:0] pl;
        row_t                              row;
        centre_t                           fixed_res;

        err_count    = 0;
        src_idle_pct = 26;
        snk_idle_pct = 86;
        win_fill     = 0;
        for (int k = 0; k < ptgf_pkg::WINDOW_LEN; k++)
        begin
            win_val[k] = '0;
            win_ok[k]  = 1'b0;
        end
        rst_n                <= 1'b0;
        pitch_if.valid       <= 1'b0;
        pitch_if.pitch_valid <= 1'b0;
        pitch_if.pitch_log2  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[n])
        begin
            row = DIRECTED_ROWS[n];
            fixed_res.sv = row.ev;
            fixed_res.lv = row.el;
            send_word(row.pv, row.pl, row.fixed_exp, fixed_res);
        end

        // Mostly a plausible pitch track with short unvoiced gaps and octave jumps; a
        // fraction of the words are wholly random.
        track    = 0;
        gap_left = 0;
        fixed_res = '0;
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 86 : 0;
            snk_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 26 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    pv = 1'(($urandom_range(1)));
                    pl = ptgf_pkg::VAL_W'($urandom);
                end
                else if (gap_left > 0 || $urandom_range(99) < 20)
                begin
                    if (gap_left == 0)
                        gap_left = $urandom_range(6);
                    else
                        gap_left--;
                    pv = 1'b0;
                    pl = ptgf_pkg::VAL_W'($urandom);
                end
                else
                begin
                    if ($urandom_range(99) < 10)
                        track = track + ($urandom_range(1) ? 2048 : -2048)
                                      * $urandom_range(1, 3) + $urandom_range(0, 600) - 300;
                    else if ($urandom_range(99) < 5)
                        track = $urandom_range(1) ? 32767 - $urandom_range(0, 1500)
                                                  : -32768 + $urandom_range(0, 1500);
                    else
                        track = track + $urandom_range(0, 200) - 100;
                    if (track > 32767)
                        track = 32767;
                    if (track < -32768)
                        track = -32768;
                    pv = 1'b1;
                    pl = ptgf_pkg::VAL_W'(track);
                end
                send_word(pv, pl, 1'b0, fixed_res);
            end
        end
        pitch_if.valid <= 1'b0;

        while (centre_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
